// ===== rtl/bpc_pkg.sv =====
package bpc_pkg;

    // field and coefficient widths
    localparam int RAW_W   = 24;
    localparam int COEF_W  = 16;
    localparam int PRES_W  = 24;
    localparam int TEMP_W  = 19;
    localparam int NUM_COEF = 6;
    localparam int IDX_W   = 3;

    // internal widths, sized to the exact value ranges
    localparam int DT_W    = RAW_W + 1;                 // raw temperature minus reference
    localparam int PROD_W  = DT_W + COEF_W + 1;         // dt times a coefficient
    localparam int OFF_W   = 38;
    localparam int SENS_W  = 35;
    localparam int SPLIT_W = 18;                        // low slice of sensitivity
    localparam int PP_W    = 42;                        // one partial product
    localparam int FULL_W  = PP_W + SPLIT_W;            // raw pressure times sensitivity
    localparam int QUOT_W  = 39;
    localparam int DIFF_W  = 40;

    // shifts of the compensation formula
    localparam int C5_SHIFT   = 8;
    localparam int C2_SHIFT   = 18;
    localparam int C1_SHIFT   = 17;
    localparam int TEMP_SHIFT = 23;
    localparam int OFF_SHIFT  = 5;
    localparam int SENS_SHIFT = 7;
    localparam int P1_SHIFT   = 21;
    localparam int P2_SHIFT   = 15;
    localparam int TEMP_BASE  = 2000;

    // rounding offsets that turn a floor shift into truncation toward zero
    localparam longint TEMP_BIAS = (64'sd1 <<< TEMP_SHIFT) - 1;
    localparam longint P1_BIAS   = (64'sd1 <<< P1_SHIFT) - 1;
    localparam longint P2_BIAS   = (64'sd1 <<< P2_SHIFT) - 1;

    // stream widths
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    localparam int QUEUE_DEPTH_DEF = 4;

    // coefficient register indexes
    localparam logic [IDX_W-1:0] REG_PRESSURE_SENS   = 3'd0;
    localparam logic [IDX_W-1:0] REG_PRESSURE_OFFSET = 3'd1;
    localparam logic [IDX_W-1:0] REG_SENS_TEMP       = 3'd2;
    localparam logic [IDX_W-1:0] REG_OFFSET_TEMP     = 3'd3;
    localparam logic [IDX_W-1:0] REG_REFERENCE_TEMP  = 3'd4;
    localparam logic [IDX_W-1:0] REG_TEMP_SLOPE      = 3'd5;

    typedef struct packed {
        logic [COEF_W-1:0] pressure_sens;
        logic [COEF_W-1:0] pressure_offset;
        logic [COEF_W-1:0] sens_temp;
        logic [COEF_W-1:0] offset_temp;
        logic [COEF_W-1:0] reference_temp;
        logic [COEF_W-1:0] temp_slope;
    } bpc_coef_t;

    // item handed from front to back
    typedef struct packed {
        logic [RAW_W-1:0]       raw_pressure;
        logic signed [DT_W-1:0] dt;
    } bpc_entry_t;

    typedef struct packed {
        logic holding;
        logic push;
    } bpc_front_status_t;

    typedef struct packed {
        logic full;
        logic empty;
    } bpc_queue_status_t;

endpackage

// ===== rtl/baro_pressure_compensation.sv =====
// First-order barometer compensation: each input item carries a raw 24-bit pressure and a
// raw 24-bit temperature conversion, and each gives one result item with the pressure in
// pascals and the temperature in hundredths of a degree, worked out with the six factory
// coefficients held in the configuration registers (write them while no item is in flight).
// One item is taken per clock cycle while the output is not stalled; that rate comes from
// the seven-stage compensation pipeline, whose multipliers each take one stage. An item
// passes from the input register into the queue and then through the pipeline stages. A
// stalled output holds the pipeline, and the input keeps accepting until the queue between
// input register and pipeline is full and the input register holds an item.
module baro_pressure_compensation
    import bpc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_wr_en,
    input  logic [IDX_W-1:0]       cfg_index,
    input  logic [COEF_W-1:0]      cfg_data,
    // input items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // raw_pressure[23:0], raw_temperature[47:24]
    // result items
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // pressure_pa[23:0], temperature_centi[42:24]
);

    bpc_coef_t         coef_reg;
    bpc_coef_t         coef_next;
    bpc_front_status_t front_status;
    bpc_queue_status_t queue_status;
    bpc_entry_t        front_entry;
    bpc_entry_t        back_entry;
    logic              back_pop;
    logic signed [PRES_W-1:0] pressure_pa;
    logic signed [TEMP_W-1:0] temperature_centi;

    // coefficient registers, unknown indexes ignored
    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_PRESSURE_SENS:   coef_next.pressure_sens   = cfg_data;
                REG_PRESSURE_OFFSET: coef_next.pressure_offset = cfg_data;
                REG_SENS_TEMP:       coef_next.sens_temp       = cfg_data;
                REG_OFFSET_TEMP:     coef_next.offset_temp     = cfg_data;
                REG_REFERENCE_TEMP:  coef_next.reference_temp  = cfg_data;
                REG_TEMP_SLOPE:      coef_next.temp_slope      = cfg_data;
                default:             coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    bpc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .raw_pressure    (s_axis_tdata[RAW_W-1:0]),
        .raw_temperature (s_axis_tdata[2*RAW_W-1:RAW_W]),
        .reference_temp  (coef_reg.reference_temp),
        .queue_full      (queue_status.full),
        .status          (front_status),
        .entry           (front_entry)
    );

    bpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_status.push),
        .push_entry (front_entry),
        .pop        (back_pop),
        .pop_entry  (back_entry),
        .status     (queue_status)
    );

    bpc_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .queue_empty       (queue_status.empty),
        .entry             (back_entry),
        .pop               (back_pop),
        .coef              (coef_reg),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .pressure_pa       (pressure_pa),
        .temperature_centi (temperature_centi)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - PRES_W - TEMP_W){1'b0}},
                           temperature_centi, pressure_pa};

    // input only stalls while an item waits in front of a full queue
    a_ready_low_means_backed_up : assert property (
        @(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (front_status.holding && queue_status.full)
    ) else $error("input stalled without a held item and a full queue");

    // front never pushes into a full queue
    a_no_push_when_full : assert property (
        @(posedge clk) disable iff (!rst_n)
        !(front_status.push && queue_status.full)
    ) else $error("push into full queue");

    // back never takes from an empty queue
    a_no_pop_when_empty : assert property (
        @(posedge clk) disable iff (!rst_n)
        !(back_pop && queue_status.empty)
    ) else $error("pop from empty queue");

    // a held item goes to the queue in any cycle in which the queue has room
    a_push_follows_space : assert property (
        @(posedge clk) disable iff (!rst_n)
        (front_status.holding && !queue_status.full) |-> front_status.push
    ) else $error("held item not handed to queue");

endmodule

// ===== rtl/bpc_front.sv =====
module bpc_front
    import bpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [RAW_W-1:0]  raw_pressure,
    input  logic [RAW_W-1:0]  raw_temperature,
    input  logic [COEF_W-1:0] reference_temp,
    input  logic              queue_full,
    output bpc_front_status_t status,
    output bpc_entry_t        entry
);

    logic       holding_reg;
    logic       holding_next;
    logic       accept;
    logic       push;
    bpc_entry_t entry_reg;
    bpc_entry_t entry_next;

    // hand over to the queue whenever it has room
    assign push     = holding_reg && !queue_full;
    assign in_ready = !holding_reg || !queue_full;
    assign accept   = in_valid && in_ready;

    // temperature difference against the reference word
    always_comb
    begin
        entry_next.raw_pressure = raw_pressure;
        entry_next.dt = $signed({1'b0, raw_temperature})
                      - $signed({1'b0, reference_temp, {C5_SHIFT{1'b0}}});
    end

    always_comb
    begin
        priority if (accept)
        begin
            holding_next = 1'b1;
        end
        else if (push)
        begin
            holding_next = 1'b0;
        end
        else
        begin
            holding_next = holding_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holding_reg <= 1'b0;
        end
        else
        begin
            holding_reg <= holding_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry          = entry_reg;
    assign status.holding = holding_reg;
    assign status.push    = push;

endmodule

// ===== rtl/bpc_queue.sv =====
module bpc_queue
    import bpc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bpc_entry_t        push_entry,
    input  logic              pop,
    output bpc_entry_t        pop_entry,
    output bpc_queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bpc_entry_t       entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_entry    = entries_reg[rd_ptr_reg];

    // pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/bpc_back.sv =====
module bpc_back
    import bpc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     queue_empty,
    input  bpc_entry_t               entry,
    output logic                     pop,
    input  bpc_coef_t                coef,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [PRES_W-1:0] pressure_pa,
    output logic signed [TEMP_W-1:0] temperature_centi
);

    logic advance;

    // stage 1: the three dt products
    logic                     b1_valid_reg;
    logic [RAW_W-1:0]         b1_d1_reg;
    logic signed [PROD_W-1:0] b1_p_temp_reg;
    logic signed [PROD_W-1:0] b1_p_off_reg;
    logic signed [PROD_W-1:0] b1_p_sens_reg;
    logic signed [PROD_W-1:0] b1_p_temp_next;
    logic signed [PROD_W-1:0] b1_p_off_next;
    logic signed [PROD_W-1:0] b1_p_sens_next;

    // stage 2: temperature, offset, sensitivity
    logic                     b2_valid_reg;
    logic [RAW_W-1:0]         b2_d1_reg;
    logic signed [TEMP_W-1:0] b2_temp_reg;
    logic signed [OFF_W-1:0]  b2_off_reg;
    logic signed [SENS_W-1:0] b2_sens_reg;
    logic signed [TEMP_W-1:0] b2_temp_next;
    logic signed [OFF_W-1:0]  b2_off_next;
    logic signed [SENS_W-1:0] b2_sens_next;
    logic signed [PROD_W-1:0] t_bias;
    logic signed [PROD_W-1:0] t_sum;

    // stage 3: partial products of raw pressure and sensitivity
    logic                     b3_valid_reg;
    logic signed [TEMP_W-1:0] b3_temp_reg;
    logic signed [OFF_W-1:0]  b3_off_reg;
    logic [PP_W-1:0]          b3_pp_lo_reg;
    logic signed [PP_W-1:0]   b3_pp_hi_reg;
    logic [PP_W-1:0]          b3_pp_lo_next;
    logic signed [PP_W-1:0]   b3_pp_hi_next;
    logic [SPLIT_W-1:0]       sens_lo;
    logic signed [SENS_W-SPLIT_W-1:0] sens_hi;

    // stage 4: full product
    logic                     b4_valid_reg;
    logic signed [TEMP_W-1:0] b4_temp_reg;
    logic signed [OFF_W-1:0]  b4_off_reg;
    logic signed [FULL_W-1:0] b4_full_reg;
    logic signed [FULL_W-1:0] b4_full_next;

    // stage 5: product over 2^21
    logic                     b5_valid_reg;
    logic signed [TEMP_W-1:0] b5_temp_reg;
    logic signed [OFF_W-1:0]  b5_off_reg;
    logic signed [QUOT_W-1:0] b5_quot_reg;
    logic signed [QUOT_W-1:0] b5_quot_next;
    logic signed [FULL_W-1:0] q_bias;
    logic signed [FULL_W-1:0] q_sum;

    // stage 6: minus offset
    logic                     b6_valid_reg;
    logic signed [TEMP_W-1:0] b6_temp_reg;
    logic signed [DIFF_W-1:0] b6_diff_reg;
    logic signed [DIFF_W-1:0] b6_diff_next;

    // stage 7: output register
    logic                     b7_valid_reg;
    logic signed [TEMP_W-1:0] b7_temp_reg;
    logic signed [PRES_W-1:0] b7_pres_reg;
    logic signed [PRES_W-1:0] b7_pres_next;
    logic signed [DIFF_W-1:0] p_bias;
    logic signed [DIFF_W-1:0] p_sum;

    // whole pipeline moves unless a finished item waits at the output
    assign advance = !b7_valid_reg || out_ready;
    assign pop     = advance && !queue_empty;

    always_comb
    begin
        b1_p_temp_next = PROD_W'(entry.dt) * PROD_W'($signed({1'b0, coef.temp_slope}));
        b1_p_off_next  = PROD_W'(entry.dt) * PROD_W'($signed({1'b0, coef.offset_temp}));
        b1_p_sens_next = PROD_W'(entry.dt) * PROD_W'($signed({1'b0, coef.sens_temp}));
    end

    // temperature truncates toward zero, offset and sensitivity floor
    always_comb
    begin
        t_bias       = b1_p_temp_reg[PROD_W-1] ? PROD_W'(TEMP_BIAS) : '0;
        t_sum        = b1_p_temp_reg + t_bias;
        b2_temp_next = TEMP_W'(t_sum >>> TEMP_SHIFT) + TEMP_W'(TEMP_BASE);
        b2_off_next  = $signed({{(OFF_W - COEF_W - C2_SHIFT){1'b0}},
                                coef.pressure_offset, {C2_SHIFT{1'b0}}})
                     + OFF_W'(b1_p_off_reg >>> OFF_SHIFT);
        b2_sens_next = $signed({{(SENS_W - COEF_W - C1_SHIFT){1'b0}},
                                coef.pressure_sens, {C1_SHIFT{1'b0}}})
                     + SENS_W'(b1_p_sens_reg >>> SENS_SHIFT);
    end

    // sensitivity split into an unsigned low slice and a signed high slice
    always_comb
    begin
        sens_lo       = b2_sens_reg[SPLIT_W-1:0];
        sens_hi       = $signed(b2_sens_reg[SENS_W-1:SPLIT_W]);
        b3_pp_lo_next = PP_W'(b2_d1_reg) * PP_W'(sens_lo);
        b3_pp_hi_next = PP_W'($signed({1'b0, b2_d1_reg})) * PP_W'(sens_hi);
    end

    always_comb
    begin
        b4_full_next = $signed({b3_pp_hi_reg, {SPLIT_W{1'b0}}})
                     + $signed({{SPLIT_W{1'b0}}, b3_pp_lo_reg});
    end

    always_comb
    begin
        q_bias       = b4_full_reg[FULL_W-1] ? FULL_W'(P1_BIAS) : '0;
        q_sum        = b4_full_reg + q_bias;
        b5_quot_next = QUOT_W'(q_sum >>> P1_SHIFT);
    end

    always_comb
    begin
        b6_diff_next = DIFF_W'(b5_quot_reg) - DIFF_W'(b5_off_reg);
    end

    always_comb
    begin
        p_bias       = b6_diff_reg[DIFF_W-1] ? DIFF_W'(P2_BIAS) : '0;
        p_sum        = b6_diff_reg + p_bias;
        b7_pres_next = PRES_W'(p_sum >>> P2_SHIFT);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
            b5_valid_reg <= 1'b0;
            b6_valid_reg <= 1'b0;
            b7_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b1_valid_reg <= !queue_empty;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            b4_valid_reg <= b3_valid_reg;
            b5_valid_reg <= b4_valid_reg;
            b6_valid_reg <= b5_valid_reg;
            b7_valid_reg <= b6_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b1_d1_reg     <= entry.raw_pressure;
            b1_p_temp_reg <= b1_p_temp_next;
            b1_p_off_reg  <= b1_p_off_next;
            b1_p_sens_reg <= b1_p_sens_next;

            b2_d1_reg     <= b1_d1_reg;
            b2_temp_reg   <= b2_temp_next;
            b2_off_reg    <= b2_off_next;
            b2_sens_reg   <= b2_sens_next;

            b3_temp_reg   <= b2_temp_reg;
            b3_off_reg    <= b2_off_reg;
            b3_pp_lo_reg  <= b3_pp_lo_next;
            b3_pp_hi_reg  <= b3_pp_hi_next;

            b4_temp_reg   <= b3_temp_reg;
            b4_off_reg    <= b3_off_reg;
            b4_full_reg   <= b4_full_next;

            b5_temp_reg   <= b4_temp_reg;
            b5_off_reg    <= b4_off_reg;
            b5_quot_reg   <= b5_quot_next;

            b6_temp_reg   <= b5_temp_reg;
            b6_diff_reg   <= b6_diff_next;

            b7_temp_reg   <= b6_temp_reg;
            b7_pres_reg   <= b7_pres_next;
        end
    end

    assign out_valid         = b7_valid_reg;
    assign pressure_pa       = b7_pres_reg;
    assign temperature_centi = b7_temp_reg;

endmodule

// ===== tb/compensation_checker.sv =====
module compensation_checker
    import bpc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [IDX_W-1:0]       cfg_index,
    input  logic [COEF_W-1:0]      cfg_data,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // raw_pressure[23:0], raw_temperature[47:24]
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,  // pressure_pa[23:0], temperature_centi[42:24]
    output int                     fail_count,
    output int                     pending_results,
    output int                     results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint TEMP_DIV    = 64'sd1 <<< 23;
    localparam longint PRES_DIV_HI = 64'sd1 <<< 21;
    localparam longint PRES_DIV_LO = 64'sd1 <<< 15;
    localparam longint TEMP_ZERO   = 64'sd2000;
    localparam int     MAX_REPORTS = 30;

    typedef struct packed {
        logic signed [PRES_W-1:0] pressure_pa;
        logic signed [TEMP_W-1:0] temperature_centi;
    } reading_t;

    bpc_coef_t coef;
    reading_t  expected_q[$];
    int        errors = 0;
    int        checked = 0;

    // own copy of the calibration words, indexes above the last one are dropped
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_PRESSURE_SENS:   coef.pressure_sens   <= cfg_data;
                REG_PRESSURE_OFFSET: coef.pressure_offset <= cfg_data;
                REG_SENS_TEMP:       coef.sens_temp       <= cfg_data;
                REG_OFFSET_TEMP:     coef.offset_temp     <= cfg_data;
                REG_REFERENCE_TEMP:  coef.reference_temp  <= cfg_data;
                REG_TEMP_SLOPE:      coef.temp_slope      <= cfg_data;
                default: ;
            endcase
        end
    end

    // first-order compensation in 64-bit signed arithmetic
    // >>> floors, / truncates toward zero
    function automatic reading_t compensate(input logic [RAW_W-1:0] raw_p,
                                            input logic [RAW_W-1:0] raw_t,
                                            input bpc_coef_t c);
        longint   dt;
        longint   temp;
        longint   off;
        longint   sens;
        longint   pres;
        reading_t r;
        dt   = longint'(raw_t) - (longint'(c.reference_temp) <<< 8);
        temp = dt * longint'(c.temp_slope) / TEMP_DIV + TEMP_ZERO;
        off  = (longint'(c.pressure_offset) <<< 18) + ((dt * longint'(c.offset_temp)) >>> 5);
        sens = (longint'(c.pressure_sens) <<< 17) + ((dt * longint'(c.sens_temp)) >>> 7);
        pres = (longint'(raw_p) * sens / PRES_DIV_HI - off) / PRES_DIV_LO;
        r.pressure_pa       = pres[PRES_W-1:0];
        r.temperature_centi = temp[TEMP_W-1:0];
        return r;
    endfunction

    task automatic report(input string what);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("[%0t] result %0d: %s", $time, checked, what);
    endtask

    // predict on each accepted input item, compare each accepted result item
    always @(posedge clk)
    begin : track
        reading_t want;
        reading_t got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(compensate(s_axis_tdata[RAW_W-1:0],
                                                s_axis_tdata[2*RAW_W-1:RAW_W], coef));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.pressure_pa       = m_axis_tdata[PRES_W-1:0];
                got.temperature_centi = m_axis_tdata[PRES_W+TEMP_W-1:PRES_W];
                if (expected_q.size() == 0)
                begin
                    report($sformatf("item with nothing expected, pressure %0d temperature %0d",
                                     got.pressure_pa, got.temperature_centi));
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.pressure_pa !== want.pressure_pa)
                        report($sformatf("pressure_pa %0d, expected %0d",
                                         got.pressure_pa, want.pressure_pa));
                    if (got.temperature_centi !== want.temperature_centi)
                        report($sformatf("temperature_centi %0d, expected %0d",
                                         got.temperature_centi, want.temperature_centi));
                    if (m_axis_tdata[OUT_TDATA_W-1:PRES_W+TEMP_W] !== '0)
                        report($sformatf("padding bits %b, expected zero",
                                         m_axis_tdata[OUT_TDATA_W-1:PRES_W+TEMP_W]));
                end
                checked++;
            end
            pending_results <= expected_q.size();
            fail_count      <= errors;
            results_checked <= checked;
        end
    end

endmodule

// ===== tb/baro_pressure_compensation_tb.sv =====
module baro_pressure_compensation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpc_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_ITEMS    = 48;
    localparam int DRAIN_CYCLES  = 24;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 130;
    localparam int RAW_MAX       = (1 << RAW_W) - 1;

    localparam logic [RAW_W-1:0] RAW_TOP = RAW_W'(RAW_MAX);
    localparam logic [RAW_W-1:0] TYP_PRESSURE    = 24'd9085466;
    localparam logic [RAW_W-1:0] TYP_TEMPERATURE = 24'd8569150;

    // register order as written, plus two indexes past the last register
    localparam logic [IDX_W-1:0] COEF_REG [NUM_COEF] = '{REG_PRESSURE_SENS, REG_PRESSURE_OFFSET,
        REG_SENS_TEMP, REG_OFFSET_TEMP, REG_REFERENCE_TEMP, REG_TEMP_SLOPE};
    localparam logic [IDX_W-1:0] REG_UNUSED_LO = IDX_W'(NUM_COEF);
    localparam logic [IDX_W-1:0] REG_UNUSED_HI = '1;

    typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PATTERN, SINK_SPARSE} sink_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [IDX_W-1:0]       cfg_index;
    logic [COEF_W-1:0]      cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // raw_pressure[23:0], raw_temperature[47:24]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // pressure_pa[23:0], temperature_centi[42:24]

    int fail_count;
    int pending_results;
    int results_checked;

    logic [COEF_W-1:0] coef_now [NUM_COEF];
    bit                hold_request = 1'b0;
    int                items_sent = 0;
    int                settings_loaded = 0;
    int                burst_left = 0;
    int                cycle_count = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    baro_pressure_compensation dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    compensation_checker result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    // offer one item, wait for it to be taken, then optionally go quiet
    task automatic send_item(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t,
                             input int gap);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {raw_t, raw_p};
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
    endtask

    // write all six calibration words, then two indexes that must be ignored
    task automatic load_coefs();
        for (int i = 0; i < NUM_COEF; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= COEF_REG[i];
            cfg_data  <= coef_now[COEF_REG[i]];
            @(posedge clk);
        end
        cfg_index <= REG_UNUSED_LO;
        cfg_data  <= COEF_W'($urandom);
        @(posedge clk);
        cfg_index <= REG_UNUSED_HI;
        cfg_data  <= COEF_W'($urandom);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        settings_loaded++;
    endtask

    // raw reading: extremes, plain random, or close to the reference temperature
    function automatic logic [RAW_W-1:0] draw_raw(input bit near_reference);
        int pick;
        int centre;
        int value;
        pick   = $urandom_range(0, 9);
        centre = int'(coef_now[REG_REFERENCE_TEMP]) <<< 8;
        value  = centre + int'($urandom_range(0, 131071)) - 65536;
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        if (near_reference && pick < 6)
        begin
            if (value < 0)
                value = 0;
            else if (value > RAW_MAX)
                value = RAW_MAX;
            return value[RAW_W-1:0];
        end
        return RAW_W'($urandom);
    endfunction

    // result side: changing stall patterns, and one long hold-off on request
    initial
    begin : result_sink
        sink_mode_t mode;
        int         mode_left;
        int         step_in_mode;
        int         held;
        mode         = SINK_OPEN;
        mode_left    = 0;
        step_in_mode = 0;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode         = sink_mode_t'($urandom_range(0, 3));
                    mode_left    = $urandom_range(16, 160);
                    step_in_mode = 0;
                end
                mode_left--;
                step_in_mode++;
                case (mode)
                    SINK_OPEN:    m_axis_tready <= 1'b1;
                    SINK_RANDOM:  m_axis_tready <= 1'($urandom_range(0, 1));
                    SINK_PATTERN: m_axis_tready <= (step_in_mode % 8) < 3;
                    default:      m_axis_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results);
            $display("== FAIL ==");
            $finish;
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        int gap;
        int pick;
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= REG_PRESSURE_SENS;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // coefficients straight out of reset are all zero
        send_item('0, '0, 1);
        send_item(RAW_TOP, RAW_TOP, 0);
        send_item(RAW_TOP, '0, 2);
        wait_idle();

        // typical factory calibration
        coef_now = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
        load_coefs();
        send_item(TYP_PRESSURE, TYP_TEMPERATURE, 0);
        send_item('0, '0, 0);
        send_item(RAW_TOP, RAW_TOP, 0);
        send_item(RAW_TOP, '0, 1);
        send_item('0, RAW_TOP, 0);
        // exactly at the reference temperature, then just below it
        send_item(TYP_PRESSURE, {coef_now[REG_REFERENCE_TEMP], 8'd0}, 0);
        send_item(TYP_PRESSURE, {coef_now[REG_REFERENCE_TEMP], 8'd0} - 1'b1, 1);
        wait_idle();

        // every coefficient at its maximum
        coef_now = '{default: '1};
        load_coefs();
        send_item('0, '0, 0);
        send_item(RAW_TOP, '0, 0);
        send_item('0, RAW_TOP, 0);
        send_item(RAW_TOP, RAW_TOP, 3);
        wait_idle();

        // no base sensitivity, largest negative temperature difference
        coef_now = '{'0, '1, '1, '1, '1, '1};
        load_coefs();
        send_item(RAW_TOP, '0, 0);
        send_item('0, '0, 0);
        send_item(RAW_TOP, RAW_TOP, 1);
        wait_idle();

        // random calibrations with random readings, bursts and gaps
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                pick = $urandom_range(0, 7);
                if (phase == 1 || pick == 0)
                    coef_now[i] = '1;
                else if (pick == 1)
                    coef_now[i] = '0;
                else
                    coef_now[i] = COEF_W'($urandom);
            end
            load_coefs();
            // long output hold-off while items keep coming back to back
            if (phase == 2)
                hold_request = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (phase == 2 && k < HOLD_ITEMS)
                begin
                    gap = 0;
                end
                else if (burst_left > 0)
                begin
                    burst_left--;
                    gap = 0;
                end
                else
                begin
                    burst_left = $urandom_range(0, 24);
                    gap        = $urandom_range(1, 15);
                end
                send_item(draw_raw(1'b0), draw_raw(1'b1), gap);
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d items sent under %0d calibrations, %0d results checked",
                 items_sent, settings_loaded, results_checked);
        $display("reset, typical and extreme coefficients, bursts, stalls and a long hold-off");
        if (pending_results != 0)
            $display("%0d results never arrived", pending_results);
        if (fail_count == 0 && pending_results == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bpc_pkg.sv
rtl/bpc_front.sv
rtl/bpc_queue.sv
rtl/bpc_back.sv
rtl/baro_pressure_compensation.sv
tb/compensation_checker.sv
tb/baro_pressure_compensation_tb.sv
